### sv/ndgl_pkg.sv
// Package for the nearest-direction gain lookup.
// Holds field widths, command and register codes, and the sequencer state type.
// No dependencies.
package ndgl_pkg;

    localparam int DIR_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int IDX_W      = 6;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_ADDR_W = 1;
    localparam int TABLE_MAX  = 64;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd4096;

    // Command codes on i_op
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BYPASS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNT  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

### sv/nearest_direction_gain_lookup.sv
// Nearest-direction gain lookup: table memory, scan pipeline and sequencer.
// Depends on ndgl_pkg.
//
// Usage
//   Request channel: i_start with i_op and payload is taken at a rising edge
//   where o_busy is low. A write request (OP_WRITE) stores direction and gain
//   into slot i_entry_index in the same cycle and returns no result. A query
//   request (OP_QUERY) scans entries 0 .. count-1 of the table and returns
//   the gain and index of the entry whose direction has the largest dot
//   product with the query direction; ties keep the lowest index.
//   Result channel: o_done strobes for one cycle with o_gain_out and
//   o_nearest_index. The receiver cannot stall; results are never held.
//   Configuration: i_cfg_wr_en writes register i_cfg_addr (bypass, count)
//   at once; write only while o_busy is low and no result is pending.
// Timing / throughput
//   Bypass or empty-table query: result strobes in the cycle after acceptance;
//   o_busy stays low. Scanning query: o_busy is high until all N entries (N =
//   entry count, saturated to the table depth) pass a read / multiply / sum /
//   compare pipeline at one memory read per cycle; result strobes as o_busy
//   falls. The single table read port sets the rate of one entry per cycle.
// Reset
//   i_rst_n (synchronous, active low) clears the sequencer, bypass and count.
//   Table contents are not cleared; read only slots that were written.
module nearest_direction_gain_lookup #(
    parameter int MAX_ENTRIES = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic                             i_op,
    input  logic [ndgl_pkg::IDX_W-1:0]       i_entry_index,
    input  logic signed [ndgl_pkg::DIR_W-1:0] i_dir_x,
    input  logic signed [ndgl_pkg::DIR_W-1:0] i_dir_y,
    input  logic signed [ndgl_pkg::DIR_W-1:0] i_dir_z,
    input  logic [ndgl_pkg::GAIN_W-1:0]      i_entry_gain,
    // result channel
    output logic                             o_done,
    output logic [ndgl_pkg::GAIN_W-1:0]      o_gain_out,
    output logic [ndgl_pkg::IDX_W-1:0]       o_nearest_index,
    // configuration port
    input  logic                             i_cfg_wr_en,
    input  logic [ndgl_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ndgl_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import ndgl_pkg::*;

    // Table depth is bounded by the slot field width.
    localparam int DEPTH  = (MAX_ENTRIES < TABLE_MAX) ? MAX_ENTRIES : TABLE_MAX;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CW     = COORD_WIDTH;
    localparam int PROD_W = 2 * CW;
    localparam int SUM_W  = 2 * CW + 2;
    localparam int WORD_W = 3 * CW + GAIN_W;

    // Table memory: {gain, z, y, x}
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rd_word;

    // Configuration
    logic             r_bypass;
    logic [CFG_DATA_W-1:0] r_entry_count;

    // Sequencer
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_issue;
    logic signed [CW-1:0] r_qx, r_qy, r_qz;

    // Pipeline
    logic             r_s1_vld, r_s1_first, r_s1_last;
    logic [AW-1:0]    r_s1_idx;
    logic             r_s2_vld, r_s2_first, r_s2_last;
    logic [AW-1:0]    r_s2_idx;
    logic [GAIN_W-1:0] r_s2_gain;
    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    logic             r_s3_vld, r_s3_first, r_s3_last;
    logic [AW-1:0]    r_s3_idx;
    logic [GAIN_W-1:0] r_s3_gain;
    logic signed [SUM_W-1:0] r_sum;

    // Running best
    logic signed [SUM_W-1:0] r_best_sum, n_best_sum;
    logic [AW-1:0]    r_best_idx, n_best_idx;
    logic [GAIN_W-1:0] r_best_gain, n_best_gain;

    // Result
    logic             r_done;
    logic [GAIN_W-1:0] r_gain_out;
    logic [IDX_W-1:0] r_nearest_index;

    logic             accept, is_query, quick_query, wr_en, rd_en, take_new, scan_end;
    logic [CFG_DATA_W-1:0] sat_count;
    logic signed [CW-1:0] qx_in, qy_in, qz_in;
    logic signed [CW-1:0] mx, my, mz;

    // Take the low COORD_WIDTH bits of each field as a signed component;
    // a wider component sees the field zero-extended.
    assign qx_in = CW'($unsigned(i_dir_x));
    assign qy_in = CW'($unsigned(i_dir_y));
    assign qz_in = CW'($unsigned(i_dir_z));

    assign sat_count = (r_entry_count > CFG_DATA_W'(DEPTH)) ? CFG_DATA_W'(DEPTH)
                                                            : r_entry_count;

    assign mx = r_rd_word[CW-1:0];
    assign my = r_rd_word[2*CW-1:CW];
    assign mz = r_rd_word[3*CW-1:2*CW];

    // Compare stage: strict greater keeps the lowest index on ties.
    assign take_new    = r_s3_first || (r_sum > r_best_sum);
    assign n_best_sum  = take_new ? r_sum     : r_best_sum;
    assign n_best_idx  = take_new ? r_s3_idx  : r_best_idx;
    assign n_best_gain = take_new ? r_s3_gain : r_best_gain;
    assign scan_end    = r_s3_vld && r_s3_last;

    // Next state and control
    always_comb begin
        n_state     = r_state;
        accept      = 1'b0;
        is_query    = 1'b0;
        quick_query = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                accept      = i_start;
                is_query    = accept && (i_op == OP_QUERY);
                quick_query = is_query && (r_bypass || (sat_count == '0));
                wr_en       = accept && (i_op == OP_WRITE)
                              && (CFG_DATA_W'(i_entry_index) < CFG_DATA_W'(DEPTH));
                if (is_query && !quick_query) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_en = (r_issue < r_count);
                if (scan_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass      <= 1'b0;
            r_entry_count <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_BYPASS: r_bypass      <= i_cfg_wdata[0];
                CFG_COUNT:  r_entry_count <= i_cfg_wdata;
                default:    r_bypass      <= r_bypass;
            endcase
        end
    end

    // Table memory: writes only in idle, reads only while scanning.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_entry_index[AW-1:0]] <= {i_entry_gain, qz_in, qy_in, qx_in};
        end
        if (rd_en) begin
            r_rd_word <= mem[r_issue[AW-1:0]];
        end
    end

    // Latch query and scan length at acceptance; advance read address.
    always_ff @(posedge i_clk) begin
        if (is_query) begin
            r_qx    <= qx_in;
            r_qy    <= qy_in;
            r_qz    <= qz_in;
            r_count <= CNT_W'(sat_count);
            r_issue <= '0;
        end else if (rd_en) begin
            r_issue <= r_issue + 1'b1;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= rd_en;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // Pipeline payload: read -> multiply -> sum -> compare
    always_ff @(posedge i_clk) begin
        r_s1_idx   <= r_issue[AW-1:0];
        r_s1_first <= (r_issue == '0);
        r_s1_last  <= (r_issue == r_count - 1'b1);

        r_s2_idx   <= r_s1_idx;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_gain  <= r_rd_word[WORD_W-1:3*CW];
        r_px       <= r_qx * mx;
        r_py       <= r_qy * my;
        r_pz       <= r_qz * mz;

        r_s3_idx   <= r_s2_idx;
        r_s3_first <= r_s2_first;
        r_s3_last  <= r_s2_last;
        r_s3_gain  <= r_s2_gain;
        r_sum      <= SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz);

        if (r_s3_vld) begin
            r_best_sum  <= n_best_sum;
            r_best_idx  <= n_best_idx;
            r_best_gain <= n_best_gain;
        end
    end

    // Result register: one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= quick_query || scan_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (quick_query) begin
            r_gain_out      <= UNITY_GAIN;
            r_nearest_index <= '0;
        end else if (scan_end) begin
            r_gain_out      <= n_best_gain;
            r_nearest_index <= IDX_W'(n_best_idx);
        end
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_done          = r_done;
    assign o_gain_out      = r_gain_out;
    assign o_nearest_index = r_nearest_index;

endmodule

### sv/ndgl_checker.sv
// Port-level checker for the nearest-direction gain lookup, with its bind.
// Depends on ndgl_pkg and nearest_direction_gain_lookup.
module ndgl_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_start,
    input logic                             o_busy,
    input logic                             i_op,
    input logic                             o_done,
    input logic [ndgl_pkg::GAIN_W-1:0]      o_gain_out,
    input logic [ndgl_pkg::IDX_W-1:0]       o_nearest_index
);
    import ndgl_pkg::*;

    // A result never shows while a scan is still running.
    a_no_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_done && o_busy))
        else $error("result strobe while busy");

    // Every scan ends with exactly its result.
    a_scan_ends_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(o_busy)) |-> o_done)
        else $error("scan ended without a result");

    // A result that follows no scan is the unity-gain answer.
    a_quick_result_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n) && !$past(o_busy))
            |-> (o_gain_out == UNITY_GAIN && o_nearest_index == '0))
        else $error("non-scan result is not unity gain");

    // A write request produces no result and starts no scan.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_op == OP_WRITE) |=> (!o_done && !o_busy))
        else $error("write request produced activity");

endmodule

bind nearest_direction_gain_lookup ndgl_checker u_ndgl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .i_op            (i_op),
    .o_done          (o_done),
    .o_gain_out      (o_gain_out),
    .o_nearest_index (o_nearest_index)
);

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_direction_gain_lookup.
// Needs ndgl_pkg and the block's RTL; runs directed then random requests.
module tb;
    import ndgl_pkg::*;

    localparam int RUN_LIMIT    = 1_000_000;  // cycles before the run is declared hung
    localparam int SETTLE_LIMIT = RUN_LIMIT;  // a whole phase drains; the hang guard ends it
    localparam int DRAIN_CYCLES = 8;          // write requests finish at acceptance; margin
    localparam int PHASE_ITEMS  = 195;

    typedef struct packed {
        logic signed [DIR_W-1:0] x;
        logic signed [DIR_W-1:0] y;
        logic signed [DIR_W-1:0] z;
    } t_dir;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  slot;
        t_dir              dir;
        logic [GAIN_W-1:0] gain;
    } t_request;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [IDX_W-1:0]  index;
    } t_lookup;

    // DUT signals; every input starts at a known value
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_start       = 1'b0;
    logic                     i_op          = OP_WRITE;
    logic [IDX_W-1:0]         i_entry_index = '0;
    logic signed [DIR_W-1:0]  i_dir_x       = '0;
    logic signed [DIR_W-1:0]  i_dir_y       = '0;
    logic signed [DIR_W-1:0]  i_dir_z       = '0;
    logic [GAIN_W-1:0]        i_entry_gain  = '0;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0]    i_cfg_addr    = CFG_BYPASS;
    logic [CFG_DATA_W-1:0]    i_cfg_wdata   = '0;
    logic                     o_busy;
    logic                     o_done;
    logic [GAIN_W-1:0]        o_gain_out;
    logic [IDX_W-1:0]         o_nearest_index;

    nearest_direction_gain_lookup u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_op            (i_op),
        .i_entry_index   (i_entry_index),
        .i_dir_x         (i_dir_x),
        .i_dir_y         (i_dir_y),
        .i_dir_z         (i_dir_z),
        .i_entry_gain    (i_entry_gain),
        .o_done          (o_done),
        .o_gain_out      (o_gain_out),
        .o_nearest_index (o_nearest_index),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests waiting to be driven, and lookups waiting to come back
    t_request request_q[$];
    t_lookup  lookup_expect_q[$];

    // Predictor copy of the table and the registers
    t_dir              dir_tab  [TABLE_MAX];
    logic [GAIN_W-1:0] gain_tab [TABLE_MAX];
    logic              model_bypass = 1'b0;
    logic [CFG_DATA_W-1:0] model_count = '0;

    // What the stimulus side believes the table holds, used to aim queries
    t_dir shadow_dir [TABLE_MAX];

    int  errors          = 0;
    int  writes_taken    = 0;
    int  queries_taken   = 0;
    int  lookups_checked = 0;
    int  settings_seen   = 0;
    int  cycle_count     = 0;
    int  gap_left        = 0;
    bit  start_next;
    bit  no_idle         = 1'b0;

    // ------------------------------------------------------------------
    // Predictor: exact arg-max of the dot product over the searched slots;
    // a strictly larger product is needed to move off a lower index.
    // ------------------------------------------------------------------
    function automatic t_lookup predict_lookup(t_request r);
        t_lookup res;
        int      span;
        longint  best_dot;
        longint  dot;
        span = (model_count > TABLE_MAX) ? TABLE_MAX : int'(model_count);
        res.gain  = UNITY_GAIN;
        res.index = '0;
        if (model_bypass || span == 0) begin
            return res;
        end
        best_dot = longint'(r.dir.x) * longint'(dir_tab[0].x)
                 + longint'(r.dir.y) * longint'(dir_tab[0].y)
                 + longint'(r.dir.z) * longint'(dir_tab[0].z);
        res.gain = gain_tab[0];
        for (int k = 1; k < span; k++) begin
            dot = longint'(r.dir.x) * longint'(dir_tab[k].x)
                + longint'(r.dir.y) * longint'(dir_tab[k].y)
                + longint'(r.dir.z) * longint'(dir_tab[k].z);
            if (dot > best_dot) begin
                best_dot  = dot;
                res.gain  = gain_tab[k];
                res.index = IDX_W'(k);
            end
        end
        return res;
    endfunction

    // Update the table copy on a write, queue the expected lookup on a query
    task automatic apply_request(t_request r);
        if (r.op == OP_WRITE) begin
            dir_tab[r.slot]  = r.dir;
            gain_tab[r.slot] = r.gain;
            writes_taken++;
        end else begin
            lookup_expect_q = {lookup_expect_q, predict_lookup(r)};
            queries_taken++;
        end
    endtask

    // Mostly back-to-back, sometimes a few cycles, rarely a long pause
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the head of the queue, hold it while busy, and
    // advance on acceptance. i_start gets exactly one assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_start && !o_busy) begin
                apply_request(request_q.pop_front());
                gap_left = no_idle ? 0 : pick_gap();
            end
            if (i_start && o_busy) begin
                start_next = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                start_next = 1'b0;
            end else if (request_q.size() > 0) begin
                i_op          <= request_q[0].op;
                i_entry_index <= request_q[0].slot;
                i_dir_x       <= request_q[0].dir.x;
                i_dir_y       <= request_q[0].dir.y;
                i_dir_z       <= request_q[0].dir.z;
                i_entry_gain  <= request_q[0].gain;
                start_next = 1'b1;
            end else begin
                start_next = 1'b0;
            end
            i_start <= start_next;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobe must match the oldest outstanding lookup.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (lookup_expect_q.size() == 0) begin
                $display("%0t: unexpected result gain=%0d index=%0d", $time,
                         o_gain_out, o_nearest_index);
                errors++;
            end else begin
                lookups_checked++;
                if (o_gain_out !== lookup_expect_q[0].gain) begin
                    $display("%0t: gain_out expected %0d actual %0d", $time,
                             lookup_expect_q[0].gain, o_gain_out);
                    errors++;
                end
                if (o_nearest_index !== lookup_expect_q[0].index) begin
                    $display("%0t: nearest_index expected %0d actual %0d", $time,
                             lookup_expect_q[0].index, o_nearest_index);
                    errors++;
                end
                void'(lookup_expect_q.pop_front());
            end
        end
    end

    // Hang guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t: timeout, %0d requests queued, %0d lookups outstanding", $time,
                     request_q.size(), lookup_expect_q.size());
            $display("nearest_direction_gain_lookup verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [DIR_W-1:0] clamp_coord(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return DIR_W'(v);
    endfunction

    // Random direction scaled to Q1.14 unit length
    function automatic t_dir rand_unit();
        real  a, b, c, m;
        t_dir v;
        do begin
            a = $itor($urandom_range(0, 32768)) - 16384.0;
            b = $itor($urandom_range(0, 32768)) - 16384.0;
            c = $itor($urandom_range(0, 32768)) - 16384.0;
            m = $sqrt(a * a + b * b + c * c);
        end while (m < 512.0);
        v.x = DIR_W'($rtoi(a * 16384.0 / m));
        v.y = DIR_W'($rtoi(b * 16384.0 / m));
        v.z = DIR_W'($rtoi(c * 16384.0 / m));
        return v;
    endfunction

    function automatic t_dir rand_full();
        t_dir v;
        v.x = DIR_W'($urandom);
        v.y = DIR_W'($urandom);
        v.z = DIR_W'($urandom);
        return v;
    endfunction

    task automatic push_write(int slot, t_dir d, logic [GAIN_W-1:0] g);
        t_request r;
        r.op   = OP_WRITE;
        r.slot = IDX_W'(slot);
        r.dir  = d;
        r.gain = g;
        shadow_dir[slot] = d;
        request_q = {request_q, r};
    endtask

    // Slot and gain of a query are don't-care; randomize them anyway
    task automatic push_query(t_dir d);
        t_request r;
        r.op   = OP_QUERY;
        r.slot = IDX_W'($urandom);
        r.dir  = d;
        r.gain = GAIN_W'($urandom);
        request_q = {request_q, r};
    endtask

    function automatic t_dir mk_dir(int x, int y, int z);
        t_dir v;
        v.x = clamp_coord(x);
        v.y = clamp_coord(y);
        v.z = clamp_coord(z);
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return GAIN_W'($urandom);
    endfunction

    // Query aimed at a stored direction, perturbed and rescaled, so the
    // winner moves around the table instead of sitting on a few slots
    function automatic t_dir rand_query_dir();
        t_dir base;
        int   roll, sh;
        roll = $urandom_range(0, 99);
        if (roll < 30) return rand_full();
        if (roll < 70) begin
            base = shadow_dir[$urandom_range(0, TABLE_MAX - 1)];
            sh   = $urandom_range(0, 4);
            return mk_dir((int'(base.x) + int'($urandom_range(0, 4000)) - 2000) >>> sh,
                          (int'(base.y) + int'($urandom_range(0, 4000)) - 2000) >>> sh,
                          (int'(base.z) + int'($urandom_range(0, 4000)) - 2000) >>> sh);
        end
        if (roll < 85) begin
            base = rand_unit();
            sh   = $urandom_range(0, 12);
            return mk_dir(int'(base.x) >>> sh, int'(base.y) >>> sh, int'(base.z) >>> sh);
        end
        if (roll < 95) begin
            // tiny vectors give many equal products
            return mk_dir(int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4,
                          int'($urandom_range(0, 8)) - 4);
        end
        return mk_dir(0, 0, 0);
    endfunction

    task automatic push_random_write();
        int slot, roll;
        slot = $urandom_range(0, TABLE_MAX - 1);
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            push_write(slot, rand_unit(), rand_gain());
        end else if (roll < 88) begin
            // duplicate another slot's direction to force ties
            push_write(slot, shadow_dir[$urandom_range(0, TABLE_MAX - 1)], rand_gain());
        end else begin
            push_write(slot, rand_full(), rand_gain());
        end
    endtask

    // Wait until the request queue, the block and the result queue are empty
    task automatic settle();
        int waited;
        waited = 0;
        do begin
            @(negedge i_clk);
            waited++;
        end while ((request_q.size() != 0 || i_start || o_busy ||
                    lookup_expect_q.size() != 0) && waited < SETTLE_LIMIT);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Register write: only called while idle, so the copy may change now
    task automatic write_register(logic [CFG_ADDR_W-1:0] addr, int value);
        if (addr == CFG_BYPASS) begin
            model_bypass = value[0];
        end else begin
            model_count = CFG_DATA_W'(value);
        end
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_mode(bit bypass, int count);
        settle();
        write_register(CFG_BYPASS, bypass);
        write_register(CFG_COUNT, count);
        settings_seen++;
        @(negedge i_clk);
    endtask

    // One random phase: on average three queries per write, table stays fully written
    task automatic run_random_phase(bit bypass, int count, bit quiet);
        set_mode(bypass, count);
        no_idle = quiet;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                push_random_write();
            end else begin
                push_query(rand_query_dir());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty table after reset: unity gain, index 0
        push_query(mk_dir(0, 0, 0));
        push_query(mk_dir(32767, -32768, 0));

        // Fill the whole table; low slots hold axis vectors, a duplicate
        // of slot 0 for the tie rule, and full-scale corner vectors
        push_write(0, mk_dir(16384, 0, 0), 16'd4096);
        push_write(1, mk_dir(0, 16384, 0), 16'hFFFF);
        push_write(2, mk_dir(-16384, 0, 0), 16'h0000);
        push_write(3, mk_dir(0, 0, 16384), 16'd12345);
        push_write(4, mk_dir(16384, 0, 0), 16'd777);
        push_write(5, mk_dir(32767, -32768, 32767), 16'hAAAA);
        push_write(6, mk_dir(-32768, 32767, -32768), 16'h5555);
        push_write(7, mk_dir(0, 0, -16384), 16'd1);
        for (int s = 8; s < TABLE_MAX; s++) begin
            push_write(s, rand_unit(), rand_gain());
        end

        // Full table: zero query picks slot 0, ties, extremes
        set_mode(1'b0, TABLE_MAX);
        push_query(mk_dir(0, 0, 0));
        push_query(mk_dir(16384, 0, 0));
        push_query(mk_dir(100, 100, 0));
        push_query(mk_dir(-32768, -32768, -32768));
        push_query(mk_dir(32767, 32767, 32767));
        push_query(mk_dir(32767, -32768, 32767));
        push_query(mk_dir(-1, 0, 0));
        push_query(mk_dir(0, 0, -1));
        push_query(mk_dir(1, 1, 1));

        // Bypass wins over a full table
        set_mode(1'b1, TABLE_MAX);
        push_query(mk_dir(16384, 0, 0));
        push_query(mk_dir(-32768, 32767, -32768));

        // Count above the table depth saturates
        set_mode(1'b0, 127);
        push_query(mk_dir(0, 16384, 0));
        push_query(mk_dir(-32768, 32767, -32768));

        // Single entry: always slot 0
        set_mode(1'b0, 1);
        push_query(mk_dir(-16384, 0, 0));
        push_query(mk_dir(0, 0, 16384));

        run_random_phase(1'b0, TABLE_MAX, 1'b0);
        run_random_phase(1'b0, 1, 1'b0);
        run_random_phase(1'b1, TABLE_MAX, 1'b1);
        run_random_phase(1'b0, 127, 1'b0);
        run_random_phase(1'b0, 0, 1'b0);
        run_random_phase(1'b0, 2, 1'b1);
        run_random_phase(1'b0, TABLE_MAX + 1, 1'b0);
        run_random_phase(1'b1, 0, 1'b0);
        run_random_phase(1'b0, $urandom_range(3, TABLE_MAX - 1), 1'b0);

        settle();
        if (lookup_expect_q.size() != 0) begin
            $display("%0t: %0d lookups never came back", $time, lookup_expect_q.size());
            errors += lookup_expect_q.size();
        end

        $display("Run covered %0d table writes and %0d queries; %0d lookups checked.",
                 writes_taken, queries_taken, lookups_checked);
        $display("Register settings visited: %0d (bypass, empty, single, partial, saturated).",
                 settings_seen);
        if (errors == 0) begin
            $display("nearest_direction_gain_lookup verification clean");
        end else begin
            $display("nearest_direction_gain_lookup verification failed");
        end
        $finish;
    end

endmodule
